FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked concurrent assertion, disabled while reset is low
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same, checked also during reset
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/vtp_pkg.sv
// shared types and constants of the vertex transform block
package vtp_pkg;

	localparam int DefScreenWidth  = 256;
	localparam int DefScreenHeight = 256;

	localparam int NumRegs  = 8;
	localparam int RegWidth = 64;
	localparam int RegIdxW  = 3;

	localparam logic [RegWidth-1:0] RegReset [NumRegs] = '{
		64'd281474976710656, 64'd0, 64'd65536, 64'd0,
		64'd0, 64'd281474976710656, 64'd0, 64'd65536
	};

	localparam logic signed [31:0] QOne  = 32'sd65536;
	localparam logic signed [31:0] S32Max = 32'sh7fffffff;
	localparam logic signed [31:0] S32Min = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic signed [31:0] vertex_w;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth_ndc;
		logic               in_bounds;
		logic               w_zero;
	} result_t;

endpackage

FILE: hdl/vertex_transform_project.sv
// vertex transform, perspective divide and viewport mapping pipeline
//
// input channel vertex/vertex_valid/vertex_stall carries one item per vertex:
// x, y, z, w in signed Q16.16. output channel result/result_valid/result_stall
// returns one item per vertex: screen x and y, ndc depth, in-bounds and
// zero-w flags.
// the 4x4 matrix sits in eight 64-bit registers written through cfg_wr_en,
// cfg_index and cfg_wdata; write them only while the pipeline is empty.
// stages from input accept to result_valid: one multiply stage
// (16 products), one sum/saturate stage, one divider setup stage, 32
// restoring divider stages (one quotient bit each, three lanes sharing w),
// then quotient saturate, viewport multiply and the output register.
// throughput is one vertex per cycle while the output is not stalled.
// a stall on a valid output freezes the whole pipeline and raises vertex_stall
// in the same cycle; nothing is lost or repeated.
// reset clears all valid bits and loads the identity matrix.
module vertex_transform_project #(
	parameter int SCREEN_WIDTH  = vtp_pkg::DefScreenWidth,
	parameter int SCREEN_HEIGHT = vtp_pkg::DefScreenHeight
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vtp_pkg::RegIdxW-1:0]    cfg_index,
	input  logic [vtp_pkg::RegWidth-1:0]   cfg_wdata,
	input  logic                           vertex_valid,
	output logic                           vertex_stall,
	input  vtp_pkg::vertex_t               vertex,
	output logic                           result_valid,
	input  logic                           result_stall,
	output vtp_pkg::result_t               result
);

	localparam int HalfW = SCREEN_WIDTH / 2;
	localparam int HalfH = SCREEN_HEIGHT / 2;
	localparam int DivSteps = 32;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [15:0] nlo;
		logic        neg;
		logic        num_neg;
		logic        ovf;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0] lane;
		logic [31:0]     den;
		logic            wz;
	} div_stage_t;

	logic [vtp_pkg::RegWidth-1:0] mat_q [vtp_pkg::NumRegs];
	logic adv;

	logic signed [47:0] prod_s1 [4][4];
	logic               v_s1;
	logic signed [31:0] clip_s2 [4];
	logic               v_s2;
	div_stage_t         div_s3 [0:DivSteps];
	logic               v_s3 [0:DivSteps];
	logic signed [31:0] quo_s4 [3];
	logic               wz_s4;
	logic               v_s4;
	logic signed [49:0] px_s5;
	logic signed [49:0] py_s5;
	logic signed [31:0] nz_s5;
	logic               wz_s5;
	logic               v_s5;
	logic               result_valid_q;
	vtp_pkg::result_t   result_q;

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		if (v > 51'(vtp_pkg::S32Max)) r = vtp_pkg::S32Max;
		else if (v < 51'(vtp_pkg::S32Min)) r = vtp_pkg::S32Min;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] entry(input int row, input int col);
		logic [63:0] r;
		r = mat_q[row*2 + col/2];
		return (col % 2 == 0) ? $signed(r[63:32]) : $signed(r[31:0]);
	endfunction

	function automatic div_lane_t div_step(input div_lane_t l, input logic [31:0] d,
			input logic bin);
		div_lane_t o;
		logic [32:0] r2;
		logic ge;
		o = l;
		r2 = {l.rem, bin};
		ge = r2 >= {1'b0, d};
		o.rem = ge ? 32'(r2 - {1'b0, d}) : r2[31:0];
		o.quo = {l.quo[30:0], ge};
		return o;
	endfunction

	function automatic logic signed [31:0] div_final(input div_lane_t l, input logic wz);
		logic signed [31:0] r;
		if (wz) r = l.num_neg ? vtp_pkg::S32Min : vtp_pkg::S32Max;
		else if (l.ovf) r = l.neg ? vtp_pkg::S32Min : vtp_pkg::S32Max;
		else if (l.neg) r = (l.quo > 32'h80000000) ? vtp_pkg::S32Min : $signed(-l.quo);
		else r = l.quo[31] ? vtp_pkg::S32Max : $signed(l.quo);
		return r;
	endfunction

	assign adv = !(result_valid_q && result_stall);
	assign vertex_stall = !adv;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vtp_pkg::NumRegs; i++) mat_q[i] <= vtp_pkg::RegReset[i];
		end else if (cfg_wr_en) begin
			mat_q[cfg_index] <= cfg_wdata;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= DivSteps; k++) v_s3[k] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= vertex_valid;
			v_s2 <= v_s1;
			v_s3[0] <= v_s2;
			for (int k = 0; k < DivSteps; k++) v_s3[k+1] <= v_s3[k];
			v_s4 <= v_s3[DivSteps];
			v_s5 <= v_s4;
			result_valid_q <= v_s5;
		end
	end

	// products, floored to Q16.16
	always_ff @(posedge clk) begin
		logic signed [31:0] vin [4];
		logic signed [63:0] p;
		if (adv) begin
			vin[0] = vertex.vertex_x;
			vin[1] = vertex.vertex_y;
			vin[2] = vertex.vertex_z;
			vin[3] = vertex.vertex_w;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					p = entry(r, c) * vin[c];
					prod_s1[r][c] <= p[63:16];
				end
			end
		end
	end

	// row sums, saturated to clip coordinates
	always_ff @(posedge clk) begin
		logic signed [50:0] acc;
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				acc = 51'(prod_s1[r][0]) + 51'(prod_s1[r][1])
					+ 51'(prod_s1[r][2]) + 51'(prod_s1[r][3]);
				clip_s2[r] <= sat32(acc);
			end
		end
	end

	// divider setup: magnitudes, signs, overflow test
	always_ff @(posedge clk) begin
		logic [31:0] mn;
		logic [31:0] md;
		logic        wz;
		if (adv) begin
			md = clip_s2[3][31] ? 32'(-clip_s2[3]) : clip_s2[3];
			wz = (clip_s2[3] == 32'sd0);
			div_s3[0].den <= md;
			div_s3[0].wz  <= wz;
			for (int i = 0; i < 3; i++) begin
				mn = clip_s2[i][31] ? 32'(-clip_s2[i]) : clip_s2[i];
				div_s3[0].lane[i].num_neg <= clip_s2[i][31];
				div_s3[0].lane[i].neg <= clip_s2[i][31] ^ clip_s2[3][31];
				div_s3[0].lane[i].nlo <= mn[15:0];
				div_s3[0].lane[i].quo <= '0;
				// quotient needs more than 32 bits when |n| >= |d| * 2^16
				if (!wz && ({16'd0, mn} >= {md, 16'd0})) begin
					div_s3[0].lane[i].ovf <= 1'b1;
					div_s3[0].lane[i].rem <= '0;
				end else begin
					div_s3[0].lane[i].ovf <= 1'b0;
					div_s3[0].lane[i].rem <= wz ? 32'd0 : {16'd0, mn[31:16]};
				end
			end
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		always_ff @(posedge clk) begin
			logic bin;
			if (adv) begin
				div_s3[k+1].den <= div_s3[k].den;
				div_s3[k+1].wz  <= div_s3[k].wz;
				for (int i = 0; i < 3; i++) begin
					bin = (k < 16) ? div_s3[k].lane[i].nlo[15 - (k % 16)] : 1'b0;
					if (div_s3[k].wz || div_s3[k].lane[i].ovf)
						div_s3[k+1].lane[i] <= div_s3[k].lane[i];
					else
						div_s3[k+1].lane[i] <= div_step(div_s3[k].lane[i],
							div_s3[k].den, bin);
				end
			end
		end
	end

	// signed, saturated quotients
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				quo_s4[i] <= div_final(div_s3[DivSteps].lane[i], div_s3[DivSteps].wz);
			wz_s4 <= div_s3[DivSteps].wz;
		end
	end

	// viewport scale
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5 <= quo_s4[0] * $signed(18'(HalfW));
			py_s5 <= quo_s4[1] * $signed(18'(HalfH));
			nz_s5 <= quo_s4[2];
			wz_s5 <= wz_s4;
		end
	end

	// viewport offset and output register
	always_ff @(posedge clk) begin
		logic signed [50:0] sx;
		logic signed [50:0] sy;
		if (adv) begin
			sx = ($signed(51'(HalfW)) <<< 16) + 51'(px_s5);
			sy = ($signed(51'(HalfH)) <<< 16) - 51'(py_s5);
			result_q.screen_x  <= sat32(sx);
			result_q.screen_y  <= sat32(sy);
			result_q.depth_ndc <= nz_s5;
			result_q.in_bounds <= (nz_s5 >= -vtp_pkg::QOne) && (nz_s5 <= vtp_pkg::QOne);
			result_q.w_zero    <= wz_s5;
		end
	end

endmodule

FILE: hdl/vtp_checker.sv
// port-level checks of the vertex transform block and their binding
`include "assert_macros.svh"

module vtp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input vtp_pkg::result_t result
);

	`CHK_ASSERT(a_hold_valid, result_valid && result_stall |=> result_valid, "result dropped while stalled")
	`CHK_ASSERT(a_hold_data, result_valid && result_stall |=> $stable(result), "result changed while stalled")
	`CHK_ASSERT(a_wz_bounds, result_valid && result.w_zero |-> !result.in_bounds, "zero w item flagged in bounds")
	`CHK_ASSERT(a_wz_depth, result_valid && result.w_zero |-> (result.depth_ndc == vtp_pkg::S32Max || result.depth_ndc == vtp_pkg::S32Min), "zero w depth not saturated")
	`CHK_ASSERT(a_bounds, result_valid && result.in_bounds |-> (result.depth_ndc >= -vtp_pkg::QOne && result.depth_ndc <= vtp_pkg::QOne), "in_bounds with depth out of range")

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: tb/testbench.sv
// self-checking testbench of the vertex transform, divide and viewport pipeline
`timescale 1ns / 1ps

module testbench;

	typedef enum logic [vtp_pkg::RegIdxW-1:0] {
		ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
		ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
	} reg_index_e;

	localparam longint HalfW = vtp_pkg::DefScreenWidth / 2;
	localparam longint HalfH = vtp_pkg::DefScreenHeight / 2;
	localparam longint QUnit = 65536;
	localparam longint Max32 = 64'sd2147483647;
	localparam longint Min32 = -64'sd2147483648;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wr_en = 1'b0;
	logic [vtp_pkg::RegIdxW-1:0]  cfg_index = '0;
	logic [vtp_pkg::RegWidth-1:0] cfg_wdata = '0;
	logic                         vertex_valid = 1'b0;
	logic                         vertex_stall;
	vtp_pkg::vertex_t             vertex = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	vtp_pkg::result_t             result;

	vtp_pkg::vertex_t             pending_vertices [$];
	vtp_pkg::result_t             expected_results [$];
	logic [vtp_pkg::RegWidth-1:0] matrix_shadow [vtp_pkg::NumRegs];
	bit                           steady = 1'b0;
	int                           errors = 0;
	int                           checked = 0;
	int                           zero_w_seen = 0;
	int                           in_bounds_seen = 0;

	vertex_transform_project dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > Max32) return Max32;
		if (v < Min32) return Min32;
		return v;
	endfunction

	function automatic longint matrix_entry(int r, int c);
		logic [63:0] word;
		word = matrix_shadow[r * 2 + c / 2];
		if (c % 2 == 0) return longint'($signed(word[63:32]));
		return longint'($signed(word[31:0]));
	endfunction

	function automatic longint ndc_quotient(longint num, longint den);
		if (den == 0) return (num >= 0) ? Max32 : Min32;
		return clamp32((num * QUnit) / den);
	endfunction

	function automatic vtp_pkg::result_t project_vertex(vtp_pkg::vertex_t v);
		longint comp [4];
		longint clip [4];
		longint acc, nx, ny, nz;
		vtp_pkg::result_t r;
		comp[0] = longint'(v.vertex_x);
		comp[1] = longint'(v.vertex_y);
		comp[2] = longint'(v.vertex_z);
		comp[3] = longint'(v.vertex_w);
		for (int row = 0; row < 4; row++) begin
			acc = 0;
			// arithmetic shift gives the floor of the q32.32 product
			for (int c = 0; c < 4; c++)
				acc += (matrix_entry(row, c) * comp[c]) >>> 16;
			clip[row] = clamp32(acc);
		end
		nx = ndc_quotient(clip[0], clip[3]);
		ny = ndc_quotient(clip[1], clip[3]);
		nz = ndc_quotient(clip[2], clip[3]);
		r.screen_x  = 32'(clamp32(HalfW * QUnit + nx * HalfW));
		r.screen_y  = 32'(clamp32(HalfH * QUnit - ny * HalfH));
		r.depth_ndc = 32'(nz);
		r.in_bounds = (nz >= -QUnit && nz <= QUnit);
		r.w_zero    = (clip[3] == 0);
		return r;
	endfunction

	task automatic add_vertex(vtp_pkg::vertex_t v);
		pending_vertices = {pending_vertices, v};
	endtask

	// driver: next item goes out once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid <= 1'b0;
		end else if (!vertex_valid || !vertex_stall) begin
			if (pending_vertices.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
				vtp_pkg::vertex_t nv;
				nv = pending_vertices.pop_front();
				expected_results = {expected_results, project_vertex(nv)};
				vertex <= nv;
				vertex_valid <= 1'b1;
			end else begin
				vertex_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_stall <= 1'b0;
		else result_stall <= !steady && ($urandom_range(99) < 20);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected item %h", $time, result);
				errors++;
			end else begin
				vtp_pkg::result_t e;
				e = expected_results.pop_front();
				checked++;
				if (e.w_zero) zero_w_seen++;
				if (e.in_bounds) in_bounds_seen++;
				if (result.screen_x !== e.screen_x) begin
					$display("%0t: screen_x expected %h actual %h", $time, e.screen_x,
						result.screen_x);
					errors++;
				end
				if (result.screen_y !== e.screen_y) begin
					$display("%0t: screen_y expected %h actual %h", $time, e.screen_y,
						result.screen_y);
					errors++;
				end
				if (result.depth_ndc !== e.depth_ndc) begin
					$display("%0t: depth_ndc expected %h actual %h", $time, e.depth_ndc,
						result.depth_ndc);
					errors++;
				end
				if (result.in_bounds !== e.in_bounds) begin
					$display("%0t: in_bounds expected %b actual %b", $time, e.in_bounds,
						result.in_bounds);
					errors++;
				end
				if (result.w_zero !== e.w_zero) begin
					$display("%0t: w_zero expected %b actual %b", $time, e.w_zero,
						result.w_zero);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(reg_index_e idx, logic [63:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		matrix_shadow[idx] = data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_vertices.size() != 0 || expected_results.size() != 0);
		repeat (45) @(posedge clk);
	endtask

	function automatic vtp_pkg::vertex_t make_vertex(logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [31:0] w);
		vtp_pkg::vertex_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.vertex_z = z;
		v.vertex_w = w;
		return v;
	endfunction

	function automatic logic [31:0] pick_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(16 << 16)) - (8 << 16);
			2: return $urandom_range(3) == 0 ? 32'h7fffffff :
				($urandom_range(1) ? 32'h80000000 : $urandom_range(3) - 1);
			default: return $signed($urandom_range(1 << 20)) - (1 << 19);
		endcase
	endfunction

	function automatic vtp_pkg::vertex_t random_vertex();
		int mode;
		logic [31:0] w;
		mode = $urandom_range(3);
		case ($urandom_range(9))
			0: w = 32'h0;
			1, 2: w = pick_coord(mode);
			3: w = $urandom;
			default: w = 32'h10000 + $urandom_range(8 << 16);
		endcase
		return make_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode), w);
	endfunction

	task automatic load_matrix(int kind);
		for (int i = 0; i < vtp_pkg::NumRegs; i++) begin
			logic [63:0] word;
			case (kind)
				0: word = vtp_pkg::RegReset[i];
				1: word = 64'h7fffffff_7fffffff;
				2: word = 64'h80000000_80000000;
				3: word = 64'h0;
				4: word = {$urandom, $urandom};
				default: begin
					logic [31:0] a, b;
					a = $signed($urandom_range(4 << 16)) - (2 << 16);
					b = $signed($urandom_range(4 << 16)) - (2 << 16);
					word = {a, b};
				end
			endcase
			write_reg(reg_index_e'(i), word);
		end
	endtask

	initial begin
		for (int i = 0; i < vtp_pkg::NumRegs; i++) matrix_shadow[i] = vtp_pkg::RegReset[i];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix: extremes, zero w, depth at the edges of the unit range
		add_vertex(make_vertex(0, 0, 0, 32'h10000));
		add_vertex(make_vertex(0, 0, 0, 0));
		add_vertex(make_vertex(32'h10000, 32'hffff0000, 32'h80000000, 0));
		add_vertex(make_vertex(32'hffff0000, 32'h10000, 32'h10000, 0));
		add_vertex(make_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff));
		add_vertex(make_vertex(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000));
		add_vertex(make_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h10000));
		add_vertex(make_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 1));
		add_vertex(make_vertex(32'h10000, 32'h10000, 32'h10000, 32'h10000));
		add_vertex(make_vertex(32'hffff0000, 32'hffff0000, 32'hffff0000,
			32'h10000));
		add_vertex(make_vertex(0, 0, 32'h10001, 32'h10000));
		add_vertex(make_vertex(0, 0, 32'hfffeffff, 32'h10000));
		add_vertex(make_vertex(32'h8000, 32'h8000, 32'h20000, 32'h20000));
		add_vertex(make_vertex(32'h30000, 32'h10000, 32'h10000,
			32'hffff0000));
		add_vertex(make_vertex(1, 32'hffffffff, 7, 3));
		add_vertex(make_vertex(32'h55555555, 32'haaaaaaaa, 32'h12345678,
			32'h00020000));
		add_vertex(make_vertex(32'haaaaaaaa, 32'h55555555, 32'hedcba987,
			32'hfffe0000));
		wait_drained();

		// matrix settings: identity, both extremes, zero, fully random, small random
		for (int phase = 0; phase < 8; phase++) begin
			load_matrix(phase % 6);
			steady = (phase == 5);
			for (int n = 0; n < 230; n++) add_vertex(random_vertex());
			wait_drained();
			steady = 1'b0;
		end
		load_matrix(0);

		$display("checked %0d vertices over eight matrix settings", checked);
		$display("%0d had zero clip w, %0d had depth in the unit range", zero_w_seen,
			in_bounds_seen);
		if (errors == 0) begin
			$display("vertex_transform_project regression: pass");
		end else begin
			$display("vertex_transform_project regression: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("vertex_transform_project regression: fail");
		$finish;
	end

endmodule
